### rtl/core/text_console_writer_defines.svh
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TCW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// implication whose consequent is checked in the next cycle
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### rtl/core/tcw_pkg.sv
// package: sizes, codes and types of the text console writer
`default_nettype none
package tcw_pkg;
  localparam int Cols = 80;
  localparam int Rows = 25;
  localparam int Cells = Cols * Rows;
  localparam int AddrW = $clog2(Cells);
  localparam int ColW = 7;
  localparam int LineW = 5;

  localparam logic [7:0] NewlineCode = 8'd10;
  localparam logic [7:0] ErrorChar = 8'h45;
  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] DefAttrReset = 8'd15;
  localparam logic [7:0] ErrAttrReset = 8'd244;

  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CLEAR,
    OP_READ,
    OP_NONE
  } op_t;

  // classified command from front to back
  typedef struct packed {
    op_t              op;
    logic             use_cursor;
    logic             in_range;
    logic [AddrW-1:0] pos;
    logic [ColW-1:0]  col;
    logic [LineW-1:0] row;
    logic [7:0]       char_code;
    logic [7:0]       attr;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_CLEAR,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_SCROLL_ZERO,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [ColW-1:0]  cursor_column;
    logic [LineW-1:0] cursor_line;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic             error_flag;
  } result_t;

  localparam logic [0:0] RegDefAttr = 1'b0;
  localparam logic [0:0] RegErrAttr = 1'b1;
endpackage
`default_nettype wire

### rtl/core/tcw_ram.sv
// generic single-port RAM with registered read
`default_nettype none
module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### rtl/core/tcw_front.sv
// front: accepts items, classifies them and computes target cell addresses
`default_nettype none
module tcw_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output      logic              full,
  input  wire logic [1:0]        kind,
  input  wire logic              use_cursor,
  input  wire logic [6:0]        column,
  input  wire logic [4:0]        line,
  input  wire logic [7:0]        char_code,
  input  wire logic [7:0]        attr_in,
  input  wire logic [7:0]        default_attribute,
  input  wire logic [7:0]        error_attribute,
  output      tcw_pkg::cmd_t     cmd,
  output      logic              cmd_valid,
  input  wire logic              cmd_take
);
  import tcw_pkg::*;

  logic [QDepth-1:0] vld;
  cmd_t              q [QDepth];
  cmd_t              c;
  logic              in_range;
  logic [AddrW-1:0]  lin;
  logic              acc;

  always_comb begin
    in_range = (column < ColW'(Cols)) && (line < LineW'(Rows));
    lin = AddrW'(line) * AddrW'(Cols) + AddrW'(column);
    c = '0;
    c.use_cursor = use_cursor;
    c.in_range = in_range;
    c.char_code = char_code;
    c.attr = (attr_in == 8'd0) ? default_attribute : attr_in;
    c.pos = in_range ? lin : '0;
    c.col = in_range ? column : '0;
    c.row = in_range ? line : '0;
    unique case (kind_t'(kind))
      KIND_PUT: begin
        c.op = OP_WRITE;
        if (!use_cursor && !in_range) begin
          c.pos = AddrW'(Cells - 1);
          c.char_code = ErrorChar;
          c.attr = error_attribute;
        end
      end
      KIND_CLEAR: c.op = OP_CLEAR;
      KIND_READ:  c.op = OP_READ;
      default:    c.op = OP_NONE;
    endcase
  end

  assign full = vld[QDepth-1];
  assign acc = push && !full;
  assign cmd_valid = vld[0];
  assign cmd = q[0];

  // two-entry shift queue
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      unique case ({acc, cmd_take})
        2'b10: vld <= {vld[QDepth-2:0], 1'b1};
        2'b01: vld <= {1'b0, vld[QDepth-1:1]};
        default: vld <= vld;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      q[0] <= q[1];
    end
    if (acc) begin
      if (cmd_take) begin
        if (vld[1]) q[1] <= c; else q[0] <= c;
      end else begin
        if (vld[0]) q[1] <= c; else q[0] <= c;
      end
    end
  end

  `include "text_console_writer_defines.svh"

  `TCW_ASSERT_IMP(a_take_valid, cmd_take, cmd_valid)
  `TCW_ASSERT_IMP(a_vld_order, vld[1], vld[0])
  `TCW_ASSERT_NEXT(a_full_stays, full && !cmd_take, full)
endmodule
`default_nettype wire

### rtl/core/tcw_back.sv
// back: carries out commands on the cell store and presents results
`default_nettype none
module tcw_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tcw_pkg::cmd_t     cmd,
  input  wire logic              cmd_valid,
  output      logic              cmd_take,
  input  wire logic [7:0]        default_attribute,
  output      logic              empty,
  input  wire logic              pop,
  output      tcw_pkg::result_t  res
);
  import tcw_pkg::*;

  state_t           state, state_next;
  logic [AddrW-1:0] cursor, cursor_next;
  logic [ColW-1:0]  ccol, ccol_next;
  logic [LineW-1:0] cline, cline_next;
  logic [AddrW-1:0] idx, idx_next;
  logic             clr_done, clr_done_next;
  result_t          rres, rres_next;
  logic             we;
  logic [AddrW-1:0] addr;
  logic [15:0]      wdata, rdata;
  logic [AddrW-1:0] pos;
  logic [ColW-1:0]  pcol;
  logic [LineW-1:0] pline;
  logic             ccol_last;

  tcw_ram #(.Width(16), .Depth(Cells)) u_ram (
    .clk, .we, .addr, .wdata, .rdata
  );

  // column and row of the target, kept alongside the linear index
  always_comb begin
    pos = cmd.use_cursor ? cursor : cmd.pos;
    pcol = cmd.use_cursor ? ccol : cmd.col;
    pline = cmd.use_cursor ? cline : cmd.row;
    ccol_last = (pcol == ColW'(Cols - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cursor <= '0;
      ccol <= '0;
      cline <= '0;
      idx <= '0;
      clr_done <= 1'b0;
    end else begin
      state <= state_next;
      cursor <= cursor_next;
      ccol <= ccol_next;
      cline <= cline_next;
      idx <= idx_next;
      clr_done <= clr_done_next;
    end
  end

  always_ff @(posedge clk) begin
    rres <= rres_next;
  end

  always_comb begin
    state_next = state;
    cursor_next = cursor;
    ccol_next = ccol;
    cline_next = cline;
    idx_next = idx;
    clr_done_next = clr_done;
    rres_next = rres;
    cmd_take = 1'b0;
    we = 1'b0;
    addr = idx;
    wdata = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          rres_next = '0;
          unique case (cmd.op)
            OP_WRITE: begin
              cmd_take = 1'b1;
              if (!cmd.use_cursor && !cmd.in_range) begin
                we = 1'b1;
                addr = cmd.pos;
                wdata = {cmd.attr, cmd.char_code};
                rres_next.error_flag = 1'b1;
                state_next = ST_RESULT;
              end else if (cmd.char_code == NewlineCode) begin
                ccol_next = '0;
                if (pline == LineW'(Rows - 1)) begin
                  cline_next = pline;
                  cursor_next = AddrW'((Rows - 1) * Cols);
                  idx_next = '0;
                  state_next = ST_SCROLL_RD;
                end else begin
                  cline_next = pline + 1'b1;
                  cursor_next = pos - AddrW'(pcol) + AddrW'(Cols);
                  state_next = ST_RESULT;
                end
              end else begin
                we = 1'b1;
                addr = pos;
                wdata = {cmd.attr, cmd.char_code};
                if (ccol_last) begin
                  ccol_next = '0;
                  if (pline == LineW'(Rows - 1)) begin
                    cline_next = pline;
                    cursor_next = AddrW'((Rows - 1) * Cols);
                    idx_next = '0;
                    state_next = ST_SCROLL_RD;
                  end else begin
                    cline_next = pline + 1'b1;
                    cursor_next = pos + 1'b1;
                    state_next = ST_RESULT;
                  end
                end else begin
                  ccol_next = pcol + 1'b1;
                  cline_next = pline;
                  cursor_next = pos + 1'b1;
                  state_next = ST_RESULT;
                end
              end
            end
            OP_CLEAR: begin
              cmd_take = 1'b1;
              clr_done_next = 1'b1;
              idx_next = '0;
              cursor_next = '0;
              ccol_next = '0;
              cline_next = '0;
              state_next = ST_CLEAR;
            end
            OP_READ: begin
              cmd_take = 1'b1;
              if (cmd.in_range) begin
                addr = cmd.pos;
                state_next = ST_READ_WAIT;
              end else begin
                state_next = ST_RESULT;
              end
            end
            default: begin
              cmd_take = 1'b1;
              state_next = ST_RESULT;
            end
          endcase
        end
      end
      ST_READ_WAIT: begin
        rres_next.cell_char = rdata[7:0];
        rres_next.cell_attr = rdata[15:8];
        state_next = ST_RESULT;
      end
      ST_CLEAR: begin
        // sweep; after reset writes zero, after a clear item writes blanks
        we = 1'b1;
        addr = idx;
        wdata = clr_done ? {default_attribute, SpaceChar} : 16'd0;
        if (idx == AddrW'(Cells - 1)) begin
          idx_next = '0;
          state_next = clr_done ? ST_RESULT : ST_IDLE;
          clr_done_next = 1'b0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_SCROLL_RD: begin
        addr = idx + AddrW'(Cols);
        state_next = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        we = 1'b1;
        addr = idx;
        wdata = rdata;
        if (idx == AddrW'(Cells - Cols - 1)) begin
          idx_next = idx + 1'b1;
          state_next = ST_SCROLL_ZERO;
        end else begin
          idx_next = idx + 1'b1;
          state_next = ST_SCROLL_RD;
        end
      end
      ST_SCROLL_ZERO: begin
        we = 1'b1;
        addr = idx;
        wdata = '0;
        if (idx == AddrW'(Cells - 1)) begin
          idx_next = '0;
          state_next = ST_RESULT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_RESULT: begin
        if (pop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign empty = (state != ST_RESULT);

  always_comb begin
    res = rres;
    res.cursor_column = ccol;
    res.cursor_line = cline;
  end

  `include "text_console_writer_defines.svh"

  `TCW_ASSERT_IMP(a_cursor_col, 1'b1, ccol < ColW'(Cols))
  `TCW_ASSERT_IMP(a_cursor_line, 1'b1, cline < LineW'(Rows))
  `TCW_ASSERT_IMP(a_take_idle, cmd_take, state == ST_IDLE)
  `TCW_ASSERT_NEXT(a_result_holds, state == ST_RESULT && !pop, state == ST_RESULT)
endmodule
`default_nettype wire

### rtl/core/text_console_writer.sv
// top level: configuration registers, front and back of the console writer
//
//  port group   direction  handshake          note
//  items in     in         push / full        one item per accepted push
//  results out  out        empty / pop        one result per item
//  config       in         apb psel/penable   two 8-bit registers, pready high
//
// put: the cell is written as the item is taken; a newline only moves the cursor
// read: the ram read is registered, so the back waits in ST_READ_WAIT before the result
// scroll: each moved cell is read, then written one row up; the last row is then zeroed; one ram port
// clear: every cell is written with a blank in the default attribute
// after reset the store is swept to zero; items queue meanwhile
// up to two items wait in the front queue while the back is busy
`default_nettype none
module text_console_writer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [1:0]  kind,
  input  wire logic        use_cursor,
  input  wire logic [6:0]  column,
  input  wire logic [4:0]  line,
  input  wire logic [7:0]  char_code,
  input  wire logic [7:0]  attr_in,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [6:0]  cursor_column,
  output      logic [4:0]  cursor_line,
  output      logic [7:0]  cell_char,
  output      logic [7:0]  cell_attr,
  output      logic        error_flag,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);
  import tcw_pkg::*;

  logic [7:0] default_attribute;
  logic [7:0] error_attribute;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_take;
  result_t    res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attribute <= DefAttrReset;
      error_attribute <= ErrAttrReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        RegDefAttr: default_attribute <= pwdata[7:0];
        RegErrAttr: error_attribute <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        RegDefAttr: prdata = {24'd0, default_attribute};
        RegErrAttr: prdata = {24'd0, error_attribute};
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .clk, .rst, .push, .full, .kind, .use_cursor, .column, .line, .char_code, .attr_in,
    .default_attribute, .error_attribute, .cmd, .cmd_valid, .cmd_take
  );

  tcw_back u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_take, .default_attribute, .empty, .pop, .res
  );

  assign cursor_column = res.cursor_column;
  assign cursor_line = res.cursor_line;
  assign cell_char = res.cell_char;
  assign cell_attr = res.cell_attr;
  assign error_flag = res.error_flag;
endmodule
`default_nettype wire

### tb/text_console_writer_tb.sv
// testbench for the text console writer: directed and random items against a console predictor
`default_nettype none
module text_console_writer_tb;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] AddrDefAttr = 3'd0;
  localparam logic [2:0] AddrErrAttr = 3'd4;
  localparam logic [7:0] LastCol = 8'(Cols - 1);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind = KIND_NOP;
  logic        use_cursor = 1'b0;
  logic [6:0]  column = '0;
  logic [4:0]  line = '0;
  logic [7:0]  char_code = '0;
  logic [7:0]  attr_in = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_line;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic        error_flag;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_writer u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #60ms;
    $display("TEST FAILED");
    $finish;
  end

  // console predictor state
  logic [15:0] screen [Cells];
  int unsigned cursor_pos;
  logic [7:0]  dflt_attr;
  logic [7:0]  err_attr;
  result_t     pending_results [$];
  int          mismatches = 0;
  bit          idle_send = 1'b1;
  bit          idle_recv = 1'b1;
  int          recv_hold = 0;

  function automatic result_t predict_console(kind_t k, logic uc, logic [6:0] c,
                                              logic [4:0] l, logic [7:0] ch,
                                              logic [7:0] a);
    result_t r;
    int unsigned pos;
    bit in_range;
    r = '0;
    in_range = (c < Cols) && (l < Rows);
    if (k == KIND_PUT) begin
      if (!uc && !in_range) begin
        screen[Cells-1] = {err_attr, ErrorChar};
        r.error_flag = 1'b1;
      end else begin
        if (a == 8'd0) a = dflt_attr;
        pos = uc ? cursor_pos : l * Cols + c;
        if (pos >= Cells) pos = 0;
        if (ch == NewlineCode) pos = (pos / Cols + 1) * Cols;
        else begin
          screen[pos] = {a, ch};
          pos++;
        end
        if (pos >= Cells) begin
          for (int i = 0; i < Cells - Cols; i++) screen[i] = screen[i+Cols];
          for (int i = Cells - Cols; i < Cells; i++) screen[i] = '0;
          pos -= Cols;
        end
        cursor_pos = pos;
      end
    end else if (k == KIND_CLEAR) begin
      for (int i = 0; i < Cells; i++) screen[i] = {dflt_attr, SpaceChar};
      cursor_pos = 0;
    end else if (k == KIND_READ && in_range) begin
      {r.cell_attr, r.cell_char} = screen[l * Cols + c];
    end
    r.cursor_column = 7'(cursor_pos % Cols);
    r.cursor_line = 5'(cursor_pos / Cols);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_item(kind_t k, logic uc, logic [6:0] c, logic [4:0] l,
                           logic [7:0] ch, logic [7:0] a);
    if (idle_send) while ($urandom_range(99) < 32) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    kind <= k; use_cursor <= uc; column <= c; line <= l;
    char_code <= ch; attr_in <= a;
    do @(posedge clk); while (full);
    pending_results.push_back(predict_console(k, uc, c, l, ch, a));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == AddrDefAttr) dflt_attr = value;
    else err_attr = value;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (cursor_column !== want.cursor_column)
          report_mismatch("cursor_column", cursor_column, want.cursor_column);
        if (cursor_line !== want.cursor_line)
          report_mismatch("cursor_line", cursor_line, want.cursor_line);
        if (cell_char !== want.cell_char) report_mismatch("cell_char", cell_char, want.cell_char);
        if (cell_attr !== want.cell_attr) report_mismatch("cell_attr", cell_attr, want.cell_attr);
        if (error_flag !== want.error_flag)
          report_mismatch("error_flag", error_flag, want.error_flag);
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      pop <= 1'b0;
    end else pop <= idle_recv ? ($urandom_range(99) >= 32) : 1'b1;
  end

  task automatic test_directed();
    send_item(KIND_READ, 0, 0, 0, 0, 0);
    send_item(KIND_PUT, 0, 0, 0, 8'h41, 0);
    send_item(KIND_PUT, 0, 7'd127, 5'd31, 8'hFF, 8'hFF);
    send_item(KIND_PUT, 0, 7'(Cols), 0, 8'h41, 1);
    send_item(KIND_PUT, 0, 0, 5'(Rows), 8'h41, 1);
    send_item(KIND_READ, 0, 7'(LastCol), 5'(Rows - 1), 0, 0);
    send_item(KIND_READ, 0, 7'd127, 5'd31, 0, 0);
    send_item(KIND_PUT, 1, 7'd127, 5'd31, 8'h42, 8'h80);
    send_item(KIND_PUT, 1, 0, 0, NewlineCode, 0);
    send_item(KIND_PUT, 0, 7'(LastCol), 5'(Rows - 1), 8'h5A, 8'h01);
    send_item(KIND_READ, 0, 7'(LastCol), 5'(Rows - 2), 0, 0);
    send_item(KIND_PUT, 0, 5, 5'(Rows - 1), NewlineCode, 0);
    send_item(KIND_NOP, 1, 7'd127, 5'd31, 8'hFF, 8'hFF);
    send_item(KIND_CLEAR, 0, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 3, 3, 0, 0);
    send_item(KIND_PUT, 1, 0, 0, 8'h00, 8'h00);
    wait_drained();
  endtask

  task automatic test_registers();
    logic [7:0] vals [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    foreach (vals[i]) begin
      write_reg(AddrDefAttr, vals[i]);
      write_reg(AddrErrAttr, vals[3-i]);
      send_item(KIND_PUT, 0, 7'd100, 0, 8'h31, 0);
      send_item(KIND_PUT, 1, 0, 0, 8'h32, 0);
      send_item(KIND_READ, 0, 7'(LastCol), 5'(Rows - 1), 0, 0);
      wait_drained();
    end
  endtask

  task automatic send_random(int count, bit fill_lines);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 55)
        send_item(KIND_PUT, 1, 7'($urandom), 5'($urandom),
                  ($urandom_range(9) == 0) ? NewlineCode : 8'($urandom),
                  ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom));
      else if (r < 70)
        send_item(KIND_PUT, 0,
                  ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(Cols - 1)),
                  fill_lines ? 5'(Rows - 1) : (($urandom_range(9) == 0) ? 5'($urandom)
                                                   : 5'($urandom_range(Rows - 1))),
                  ($urandom_range(9) == 0) ? NewlineCode : 8'($urandom), 8'($urandom));
      else if (r < 97)
        send_item(KIND_READ, 1'($urandom),
                  ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(Cols - 1)),
                  ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(Rows - 1)),
                  8'($urandom), 8'($urandom));
      else if (r < 99) send_item(KIND_NOP, 1'($urandom), 7'($urandom), 5'($urandom),
                                 8'($urandom), 8'($urandom));
      else send_item(KIND_CLEAR, 1'($urandom), 7'($urandom), 5'($urandom),
                     8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_backpressure();
    recv_hold = 400;
    send_random(20, 0);
    wait_drained();
  endtask

  task automatic test_random();
    send_random(300, 0);
    wait_drained();
    write_reg(AddrDefAttr, 8'($urandom));
    write_reg(AddrErrAttr, 8'($urandom));
    idle_send = 1'b0;
    idle_recv = 1'b0;
    send_random(150, 0);
    idle_send = 1'b1;
    idle_recv = 1'b1;
    send_random(250, 1);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < Cells; i++) screen[i] = '0;
    cursor_pos = 0;
    dflt_attr = DefAttrReset;
    err_attr = ErrAttrReset;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_registers();
    test_backpressure();
    test_random();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
